[rtl/core/spr_pkg.sv]
// Shared constants and widths of the stepper move ramp profiler.
// Used by the divider unit, the top level, the checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package spr_pkg;
    localparam int NUM_AXES   = 2;
    localparam int AXIS_W     = 1;
    localparam int MAX_PERIOD = 65536;
    localparam int PERIOD_W   = 17;
    localparam int STEPS_W    = 23;
    localparam int RAMP_W     = 22;
    localparam int CLK_W      = 27;
    localparam int SPR_W      = 16;
    localparam int DVD_W      = 39;
    localparam int DVS_W      = 32;
    localparam int MULA_W     = 17;
    localparam int MULB_W     = 22;
    localparam int CNT_W      = 6;

    localparam logic [1:0] REQ_MOVE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_LAUNCH = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_STOP   = 2'd3;

    localparam logic [1:0] REG_CLK_ONE = 2'd0;
    localparam logic [1:0] REG_CLK_TWO = 2'd1;
    localparam logic [1:0] REG_SPR     = 2'd2;

    localparam logic [DVS_W-1:0] DEG_PER_REV = DVS_W'(360);
    localparam logic [DVS_W-1:0] RAMP_DIV    = DVS_W'(3);
    localparam logic [STEPS_W-1:0] RAMP_MIN  = STEPS_W'(40);
    localparam logic [STEPS_W-1:0] RAMP_KNEE = STEPS_W'(80);
endpackage
`default_nettype wire

[rtl/core/spr_div.sv]
// Restoring divider that yields one quotient bit per cycle.
// Depends on spr_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module spr_div
    import spr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             fits;
    logic             last;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign last  = busy_reg && (cnt_reg == CNT_W'(DVD_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                busy_reg <= !last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

[rtl/core/stepper_move_ramp_profiler_top.sv]
// Top level of the two-axis stepper move ramp profiler: sequencer, axis state, multiplier.
// Depends on spr_pkg and spr_div.
//
// channel  | direction | handshake               | payload
// s_axis   | in        | s_axis_tvalid/tready    | tuser req_type,axis; tdata angle,speed
// m_axis   | out       | m_axis_tvalid/tready    | tuser out_axis,action; tdata period,dir,moving
// cfg      | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// A stop, an idle tick, a cruise tick or the end of a move goes from decode straight to the done
// state, and the input is ready again once the result is in the output register.
// A move with a nonzero angle runs up to three divisions and a ramp tick two, one after another
// in the shared divider, which works through the whole 39-bit dividend for each of them.
// Reset clears all axis state and loads the register defaults.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module stepper_move_ramp_profiler_top
    import spr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // move_angle[15:0], speed_rpm[31:16]
    input  wire logic [2:0]  s_axis_tuser,  // req_type[1:0], axis[2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // step_period[16:0], direction[17], moving[18]
    output logic [2:0]       m_axis_tuser,  // out_axis[0], timer_action[2:1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [26:0] cfg_data
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_WAIT   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        PH_STEPS, PH_CRUISE, PH_RAMP, PH_FRAC, PH_PERIOD
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [CLK_W-1:0]    clk_one_reg, clk_two_reg;
    logic [SPR_W-1:0]    spr_reg;

    logic                active_reg [NUM_AXES];
    logic [STEPS_W-1:0]  left_reg   [NUM_AXES];
    logic [STEPS_W-1:0]  total_reg  [NUM_AXES];
    logic [RAMP_W-1:0]   ramp_reg   [NUM_AXES];
    logic [PERIOD_W-1:0] slow_reg   [NUM_AXES];
    logic [PERIOD_W-1:0] cruise_reg [NUM_AXES];
    logic                dir_reg    [NUM_AXES];

    logic [1:0]          req_reg;
    logic [AXIS_W-1:0]   axis_reg;
    logic [15:0]         angle_reg;
    logic [15:0]         rpm_reg;
    logic [MULA_W-1:0]   mul_a_reg;
    logic [MULB_W-1:0]   mul_b_reg;
    logic [DVD_W-1:0]    prod_reg;
    logic [STEPS_W-1:0]  steps_reg;
    logic [PERIOD_W-1:0] cr_reg;
    logic [PERIOD_W-1:0] den_reg;
    logic [1:0]          act_reg;
    logic [PERIOD_W-1:0] per_reg;

    logic                out_valid_reg;
    logic [AXIS_W-1:0]   o_axis_reg;
    logic [1:0]          o_act_reg;
    logic [PERIOD_W-1:0] o_per_reg;
    logic                o_dir_reg;
    logic                o_mov_reg;

    logic                div_start;
    logic [DVD_W-1:0]    div_dvd;
    logic [DVS_W-1:0]    div_dvs;
    logic                div_done;
    logic [DVD_W-1:0]    div_q;

    logic                neg;
    logic [15:0]         mag;
    logic [CLK_W-1:0]    clk_sel;
    logic [33:0]         clk60;
    logic [STEPS_W-1:0]  t_left, t_new, t_done, t_total, t_ramp, t_n, t_k, t_base;
    logic                t_up, t_down;
    logic [RAMP_W-1:0]   t_sel;
    logic [PERIOD_W-1:0] a_slow, a_fast;
    logic [STEPS_W-1:0]  q_steps, half, r1, r2;
    logic [PERIOD_W-1:0] q_cruise;
    logic [19:0]         start8;
    logic [PERIOD_W:0]   start_p, cr_plus;
    logic [PERIOD_W:0]   den_sum;
    logic                out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    assign neg     = angle_reg[15];
    assign mag     = neg ? 16'(~angle_reg + 16'd1) : angle_reg;
    assign clk_sel = (axis_reg == AXIS_W'(0)) ? clk_one_reg : clk_two_reg;
    assign clk60   = {1'b0, clk_sel, 6'b0} - {5'b0, clk_sel, 2'b0};

    assign a_slow  = slow_reg[axis_reg];
    assign a_fast  = cruise_reg[axis_reg];
    assign t_left  = left_reg[axis_reg];
    assign t_total = total_reg[axis_reg];
    assign t_ramp  = {1'b0, ramp_reg[axis_reg]};
    assign t_new   = t_left - 1'b1;
    assign t_done  = t_total - t_new;
    assign t_base  = t_total - t_ramp;
    assign t_up    = t_done < t_ramp;
    assign t_down  = (t_total >= t_ramp) && (t_done >= t_base);
    assign t_n     = t_done - t_base;
    assign t_k     = (t_n <= t_ramp) ? (t_ramp - t_n) : '0;
    assign t_sel   = t_up ? t_done[RAMP_W-1:0] : t_k[RAMP_W-1:0];

    assign q_steps  = (div_q == '0) ? STEPS_W'(1) : div_q[STEPS_W-1:0];
    assign q_cruise = div_q[PERIOD_W-1:0];
    assign half     = steps_reg >> 1;
    assign r1       = (div_q[STEPS_W-1:0] < RAMP_MIN) ?
                      ((steps_reg < RAMP_KNEE) ? half : RAMP_MIN) : div_q[STEPS_W-1:0];
    assign r2       = (r1 > half) ? half : r1;
    assign start8   = {cr_reg, 3'b0};
    assign cr_plus  = {1'b0, cr_reg} + (PERIOD_W+1)'(2);
    assign start_p  = (start8 > 20'(MAX_PERIOD)) ? (PERIOD_W+1)'(MAX_PERIOD)
                                                 : start8[PERIOD_W:0];
    assign den_sum  = {1'b0, a_fast} + div_q[PERIOD_W:0];

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = prod_reg;
        div_dvs   = DEG_PER_REV;
        if (state_reg == ST_DIV)
        begin
            case (phase_reg)
                PH_STEPS:  div_start = 1'b1;
                PH_CRUISE:
                begin
                    div_start = (prod_reg != '0);
                    div_dvd   = DVD_W'(clk60);
                    div_dvs   = prod_reg[DVS_W-1:0];
                end
                PH_RAMP:
                begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(steps_reg);
                    div_dvs   = RAMP_DIV;
                end
                PH_FRAC:
                begin
                    div_start = 1'b1;
                    div_dvs   = DVS_W'(ramp_reg[axis_reg]);
                end
                PH_PERIOD:
                begin
                    div_start = 1'b1;
                    div_dvs   = DVS_W'(den_reg);
                end
                default: div_start = 1'b0;
            endcase
        end
    end

    spr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_one_reg <= CLK_W'(32000000);
            clk_two_reg <= CLK_W'(32000000);
            spr_reg     <= SPR_W'(3200);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CLK_ONE: clk_one_reg <= cfg_data;
                REG_CLK_TWO: clk_two_reg <= cfg_data;
                REG_SPR:     spr_reg     <= cfg_data[SPR_W-1:0];
                default:     spr_reg     <= spr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_STEPS;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                active_reg[i] <= 1'b0;
                left_reg[i]   <= '0;
                total_reg[i]  <= '0;
                ramp_reg[i]   <= '0;
                slow_reg[i]   <= '0;
                cruise_reg[i] <= '0;
                dir_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    case (req_reg)
                        REQ_MOVE:
                        begin
                            if (mag == '0)
                            begin
                                active_reg[axis_reg] <= 1'b0;
                                left_reg[axis_reg]   <= '0;
                                state_reg            <= ST_DONE;
                            end
                            else
                            begin
                                phase_reg <= PH_STEPS;
                                state_reg <= ST_MUL;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (active_reg[axis_reg] && t_left <= STEPS_W'(1))
                            begin
                                active_reg[axis_reg] <= 1'b0;
                                left_reg[axis_reg]   <= '0;
                                state_reg            <= ST_DONE;
                            end
                            else if (active_reg[axis_reg])
                            begin
                                left_reg[axis_reg] <= t_new;
                                if ((t_up || t_down) && t_ramp != '0 && a_slow > a_fast)
                                begin
                                    phase_reg <= PH_FRAC;
                                    state_reg <= ST_MUL;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            else
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                        REQ_STOP:
                        begin
                            active_reg[axis_reg] <= 1'b0;
                            left_reg[axis_reg]   <= '0;
                            state_reg            <= ST_DONE;
                        end
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_MUL: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (div_start)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        active_reg[axis_reg] <= 1'b0;
                        left_reg[axis_reg]   <= '0;
                        state_reg            <= ST_DONE;
                    end
                end
                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        case (phase_reg)
                            PH_STEPS:
                            begin
                                dir_reg[axis_reg] <= !neg;
                                phase_reg         <= PH_CRUISE;
                                state_reg         <= ST_MUL;
                            end
                            PH_CRUISE:
                            begin
                                if (div_q < DVD_W'(2) || div_q > DVD_W'(MAX_PERIOD))
                                begin
                                    active_reg[axis_reg] <= 1'b0;
                                    left_reg[axis_reg]   <= '0;
                                    state_reg            <= ST_DONE;
                                end
                                else
                                begin
                                    phase_reg <= PH_RAMP;
                                    state_reg <= ST_DIV;
                                end
                            end
                            PH_RAMP:
                            begin
                                active_reg[axis_reg] <= 1'b1;
                                total_reg[axis_reg]  <= steps_reg;
                                left_reg[axis_reg]   <= steps_reg;
                                ramp_reg[axis_reg]   <= (r2 == '0) ? RAMP_W'(1)
                                                                   : r2[RAMP_W-1:0];
                                slow_reg[axis_reg]   <= (start_p < cr_plus) ?
                                                        cr_plus[PERIOD_W-1:0] :
                                                        start_p[PERIOD_W-1:0];
                                cruise_reg[axis_reg] <= cr_reg;
                                state_reg            <= ST_DONE;
                            end
                            PH_FRAC:
                            begin
                                phase_reg <= PH_PERIOD;
                                state_reg <= ST_MUL;
                            end
                            PH_PERIOD: state_reg <= ST_DONE;
                            default:   state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg   <= s_axis_tuser[1:0];
            axis_reg  <= s_axis_tuser[2];
            angle_reg <= s_axis_tdata[15:0];
            rpm_reg   <= s_axis_tdata[31:16];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= DVD_W'(mul_a_reg * mul_b_reg);
        end
        case (state_reg)
            ST_DECODE:
            begin
                if (req_reg == REQ_TICK && active_reg[axis_reg] && t_left > STEPS_W'(1))
                begin
                    act_reg   <= ACT_UPDATE;
                    mul_a_reg <= a_slow - a_fast;
                    mul_b_reg <= t_sel;
                    per_reg   <= ((t_up || t_down) && t_ramp == '0) ? a_slow : a_fast;
                end
                else
                begin
                    mul_a_reg <= MULA_W'(mag);
                    mul_b_reg <= MULB_W'(spr_reg);
                    per_reg   <= '0;
                    if ((req_reg == REQ_MOVE && mag == '0) || req_reg == REQ_STOP
                        || (req_reg == REQ_TICK && active_reg[axis_reg]))
                    begin
                        act_reg <= ACT_STOP;
                    end
                    else
                    begin
                        act_reg <= ACT_NONE;
                    end
                end
            end
            ST_DIV:
            begin
                if (!div_start)
                begin
                    act_reg <= ACT_STOP;
                end
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_STEPS:
                        begin
                            steps_reg <= q_steps;
                            mul_a_reg <= MULA_W'(spr_reg);
                            mul_b_reg <= MULB_W'(rpm_reg);
                        end
                        PH_CRUISE:
                        begin
                            cr_reg  <= q_cruise;
                            act_reg <= ACT_STOP;
                        end
                        PH_RAMP:
                        begin
                            act_reg <= ACT_LAUNCH;
                            per_reg <= (start_p < cr_plus) ? cr_plus[PERIOD_W-1:0]
                                                           : start_p[PERIOD_W-1:0];
                        end
                        PH_FRAC:
                        begin
                            den_reg   <= (den_sum > {1'b0, a_slow}) ? a_slow
                                                                    : den_sum[PERIOD_W-1:0];
                            mul_a_reg <= a_slow;
                            mul_b_reg <= MULB_W'(a_fast);
                        end
                        PH_PERIOD: per_reg <= q_cruise;
                        default:   per_reg <= per_reg;
                    endcase
                end
            end
            default: act_reg <= act_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_axis_reg <= axis_reg;
            o_act_reg  <= act_reg;
            o_per_reg  <= (act_reg == ACT_LAUNCH || act_reg == ACT_UPDATE) ? per_reg : '0;
            o_dir_reg  <= dir_reg[axis_reg];
            o_mov_reg  <= active_reg[axis_reg];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {o_act_reg, o_axis_reg};
    assign m_axis_tdata  = {5'b0, o_mov_reg, o_dir_reg, o_per_reg};

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_WAIT)
        else $error("divider finished outside its wait state");
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg == ST_DECODE)
        else $error("accepted item not decoded");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending transfer");
`endif
endmodule
`default_nettype wire

[sim/spr_checker.sv]
// Checker of the stepper move ramp profiler: watches the item, result and register channels,
// predicts each result from its own copy of the axis state and compares field by field.
// Depends on spr_pkg.
`timescale 1ns / 1ps
module spr_checker
    import spr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [26:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        logic       axis_id;
        logic [1:0] action;
        logic [16:0] period;
        logic       dir;
        logic       moving;
    } timer_cmd_t;

    timer_cmd_t cmd_queue[$];

    logic [26:0] clk_hz [NUM_AXES];
    logic [15:0] spr;
    logic        active   [NUM_AXES];
    logic [31:0] left     [NUM_AXES];
    logic [31:0] total    [NUM_AXES];
    logic [31:0] ramp     [NUM_AXES];
    logic [31:0] slow_p   [NUM_AXES];
    logic [31:0] cruise_p [NUM_AXES];
    logic        dir_lvl  [NUM_AXES];

    assign pending_count = cmd_queue.size();

    function automatic logic [31:0] ramp_period(logic [31:0] slow, logic [31:0] fast,
                                                 logic [31:0] n, logic [31:0] tot);
        logic [63:0] num;
        logic [63:0] den;
        if (tot == 0)
            return slow;
        if (slow <= fast)
            return fast;
        num = 64'(slow) * 64'(fast);
        den = 64'(fast) + (64'(slow - fast) * 64'(n)) / 64'(tot);
        if (den == 0)
            den = 1;
        if (den > 64'(slow))
            den = 64'(slow);
        return 32'(num / den);
    endfunction

    task automatic predict_timer_cmd(logic [1:0] req, logic a, logic [15:0] ang,
                                     logic [15:0] rpm);
        timer_cmd_t c;
        logic [31:0] mag;
        logic [63:0] steps;
        logic [63:0] denom;
        logic [63:0] cruise;
        logic [63:0] start;
        logic [63:0] rmp;
        logic [31:0] done;
        logic [31:0] n;
        logic [31:0] k;
        c = '0;
        c.axis_id = a;
        if (req == REQ_MOVE) begin
            mag = ang[15] ? (32'h10000 - 32'(ang)) : 32'(ang);
            c.action = ACT_STOP;
            if (mag == 0) begin
                active[a] = 0;
                left[a] = 0;
            end
            else begin
                steps = (64'(mag) * 64'(spr)) / 360;
                if (steps == 0)
                    steps = 1;
                dir_lvl[a] = !ang[15];
                denom = 64'(spr) * 64'(rpm);
                cruise = (denom == 0) ? 0 : (64'(clk_hz[a]) * 60) / denom;
                if (denom == 0 || cruise < 2 || cruise > MAX_PERIOD) begin
                    active[a] = 0;
                    left[a] = 0;
                end
                else begin
                    rmp = steps / 3;
                    if (rmp < 40)
                        rmp = (steps < 80) ? steps / 2 : 40;
                    if (rmp > steps / 2)
                        rmp = steps / 2;
                    if (rmp == 0)
                        rmp = 1;
                    start = cruise * 8;
                    if (start > MAX_PERIOD)
                        start = MAX_PERIOD;
                    if (start < cruise + 2)
                        start = cruise + 2;
                    active[a] = 1;
                    total[a] = 32'(steps);
                    left[a] = 32'(steps);
                    ramp[a] = 32'(rmp);
                    slow_p[a] = 32'(start);
                    cruise_p[a] = 32'(cruise);
                    c.action = ACT_LAUNCH;
                    c.period = 17'(start);
                end
            end
        end
        else if (req == REQ_TICK) begin
            if (active[a]) begin
                if (left[a] <= 1) begin
                    active[a] = 0;
                    left[a] = 0;
                    c.action = ACT_STOP;
                end
                else begin
                    left[a] = left[a] - 1;
                    done = total[a] - left[a];
                    c.action = ACT_UPDATE;
                    if (done < ramp[a])
                        c.period = 17'(ramp_period(slow_p[a], cruise_p[a], done, ramp[a]));
                    else if (total[a] >= ramp[a] && done >= total[a] - ramp[a]) begin
                        n = done - (total[a] - ramp[a]);
                        k = (n <= ramp[a]) ? ramp[a] - n : 0;
                        c.period = 17'(ramp_period(slow_p[a], cruise_p[a], k, ramp[a]));
                    end
                    else
                        c.period = 17'(cruise_p[a]);
                end
            end
        end
        else if (req == REQ_STOP) begin
            active[a] = 0;
            left[a] = 0;
            c.action = ACT_STOP;
        end
        c.dir = dir_lvl[a];
        c.moving = active[a];
        cmd_queue.push_back(c);
    endtask

    task automatic compare_timer_cmd();
        timer_cmd_t e;
        timer_cmd_t g;
        g.axis_id = m_axis_tuser[0];
        g.action  = m_axis_tuser[2:1];
        g.period  = m_axis_tdata[16:0];
        g.dir     = m_axis_tdata[17];
        g.moving  = m_axis_tdata[18];
        if (cmd_queue.size() == 0) begin
            $error("unexpected result transfer: %p", g);
            fail_count++;
            return;
        end
        e = cmd_queue.pop_front();
        if (g.axis_id !== e.axis_id) begin
            $error("out_axis: expected %0d, actual %0d", e.axis_id, g.axis_id);
            fail_count++;
        end
        if (g.action !== e.action) begin
            $error("timer_action: expected %0d, actual %0d", e.action, g.action);
            fail_count++;
        end
        if (g.period !== e.period) begin
            $error("step_period: expected %0d, actual %0d", e.period, g.period);
            fail_count++;
        end
        if (g.dir !== e.dir) begin
            $error("direction: expected %0d, actual %0d", e.dir, g.dir);
            fail_count++;
        end
        if (g.moving !== e.moving) begin
            $error("moving: expected %0d, actual %0d", e.moving, g.moving);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fail_count = 0;
            cmd_queue.delete();
            clk_hz[0] = 32000000;
            clk_hz[1] = 32000000;
            spr = 3200;
            for (int i = 0; i < NUM_AXES; i++) begin
                active[i] = 0;
                left[i] = 0;
                total[i] = 0;
                ramp[i] = 0;
                slow_p[i] = 0;
                cruise_p[i] = 0;
                dir_lvl[i] = 0;
            end
        end
        else begin
            if (m_axis_tvalid && m_axis_tready)
                compare_timer_cmd();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_CLK_ONE)
                    clk_hz[0] = cfg_data;
                else if (cfg_index == REG_CLK_TWO)
                    clk_hz[1] = cfg_data;
                else if (cfg_index == REG_SPR)
                    spr = cfg_data[15:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_timer_cmd(s_axis_tuser[1:0], s_axis_tuser[2], s_axis_tdata[15:0],
                                  s_axis_tdata[31:16]);
        end
    end
endmodule

[sim/tb_stepper_move_ramp_profiler_top.sv]
// Testbench top of the stepper move ramp profiler: clock, reset, item and register stimulus,
// receiver stalls, watchdog and verdict. Depends on spr_pkg, spr_checker and the RTL.
`timescale 1ns / 1ps
module tb_stepper_move_ramp_profiler_top;
    import spr_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [26:0] cfg_data = '0;
    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    bit          long_hold = 0;

    always #5 clk = ~clk;

    stepper_move_ramp_profiler_top u_top (.*);

    spr_checker u_chk (.*);

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stall pattern, one long hold-off, and stretches with no stall.
    initial begin
        int phase;
        phase = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            phase++;
            if (long_hold)
                m_axis_tready <= 0;
            else if ((phase / 200) % 3 == 2)
                m_axis_tready <= 1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [26:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        while (pending_count != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic send_request(logic [1:0] req, logic a, logic [15:0] ang, logic [15:0] rpm);
        s_axis_tuser <= {a, req};
        s_axis_tdata <= {rpm, ang};
        s_axis_tvalid <= 1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    // A well-formed move: launch, then mostly ticks, sometimes cut by a stop or mixed with items for the other axis.
    task automatic run_move(logic a, int rpm_lo, int rpm_hi);
        logic [15:0] ang;
        int n;
        int burst;
        ang = 16'($urandom_range(1, 20));
        if ($urandom_range(0, 1))
            ang = -ang;
        send_request(REQ_MOVE, a, ang, 16'($urandom_range(rpm_lo, rpm_hi)));
        n = $urandom_range(5, 30);
        burst = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            if (--burst == 0) begin
                pause_sender();
                burst = $urandom_range(1, 8);
            end
            case ($urandom_range(0, 19))
                0: send_request(REQ_STOP, a, 16'($urandom), 16'($urandom));
                1: send_request(REQ_NONE, !a, 16'($urandom), 16'($urandom));
                2: send_request(REQ_TICK, !a, 16'($urandom), 16'($urandom));
                default: send_request(REQ_TICK, a, 16'($urandom), 16'($urandom));
            endcase
        end
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: extremes of angle and speed, every request, each special case.
        send_request(REQ_TICK, 0, 16'h0000, 16'h0000);
        send_request(REQ_STOP, 1, 16'hFFFF, 16'hFFFF);
        send_request(REQ_NONE, 0, 16'hFFFF, 16'hFFFF);
        send_request(REQ_MOVE, 0, 16'h0000, 16'd100);
        send_request(REQ_MOVE, 1, 16'h8000, 16'd0);
        send_request(REQ_MOVE, 0, 16'h7FFF, 16'hFFFF);
        send_request(REQ_MOVE, 0, 16'd90, 16'd1);
        send_request(REQ_MOVE, 1, -16'sd5, 16'd600);
        for (int i = 0; i < 6; i++)
            send_request(REQ_TICK, 1, 16'h0000, 16'h0000);
        send_request(REQ_STOP, 1, 16'h0000, 16'h0000);
        send_request(REQ_MOVE, 0, 16'd1, 16'd60);
        send_request(REQ_TICK, 0, 16'h0000, 16'h0000);
        send_request(REQ_TICK, 0, 16'h0000, 16'h0000);
        send_request(REQ_TICK, 0, 16'h0000, 16'h0000);
        s_axis_tvalid <= 0;
        drain_results();

        // Large cruise: a cruise period beyond the limit stops the move; tiny steps per revolution.
        write_reg(REG_CLK_ONE, 27'd100000000);
        write_reg(REG_SPR, 16'd1);
        send_request(REQ_MOVE, 0, 16'd720, 16'd92);
        send_request(REQ_TICK, 0, 16'h0000, 16'h0000);
        send_request(REQ_MOVE, 0, 16'd200, 16'd1);
        s_axis_tvalid <= 0;
        drain_results();

        // Long receiver hold-off while the sender keeps offering items.
        write_reg(REG_CLK_TWO, 27'd1);
        write_reg(REG_SPR, 16'd65535);
        write_reg(REG_CLK_ONE, 27'd32000000);
        long_hold = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                long_hold = 0;
            end
            begin
                for (int i = 0; i < 8; i++)
                    send_request(REQ_TICK, 1, 16'($urandom), 16'($urandom));
                s_axis_tvalid <= 0;
            end
        join
        drain_results();

        // Random phases over several register settings.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_CLK_ONE, 27'd32000000);
                    write_reg(REG_CLK_TWO, 27'd16000000);
                    write_reg(REG_SPR, 16'd3200);
                end
                1: begin
                    write_reg(REG_CLK_ONE, 27'd100000000);
                    write_reg(REG_CLK_TWO, 27'd1000000);
                    write_reg(REG_SPR, 16'd200);
                end
                2: begin
                    write_reg(REG_CLK_ONE, 27'($urandom_range(1, 100000000)));
                    write_reg(REG_CLK_TWO, 27'h7FFFFFF);
                    write_reg(REG_SPR, 16'($urandom_range(1, 65535)));
                end
                3: begin
                    write_reg(REG_CLK_ONE, 27'd1);
                    write_reg(REG_SPR, 16'd0);
                end
                default: begin
                    write_reg(REG_CLK_ONE, 27'd20000000);
                    write_reg(REG_CLK_TWO, 27'd48000000);
                    write_reg(REG_SPR, 16'd1600);
                end
            endcase
            for (int m = 0; m < 6; m++) begin
                if ($urandom_range(0, 4) == 0)
                    send_request(2'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
                else
                    run_move(1'($urandom), 1, ph == 1 ? 65535 : 3000);
            end
            s_axis_tvalid <= 0;
            drain_results();
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[stepper_move_ramp_profiler_top.f]
rtl/core/spr_pkg.sv
rtl/core/spr_div.sv
rtl/core/stepper_move_ramp_profiler_top.sv
sim/spr_checker.sv
sim/tb_stepper_move_ramp_profiler_top.sv
